// File: rtl/assert_macros.svh
// assertion macros used by the rgb_to_hsl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond implies prop on the same edge, checked on clk and off during reset
`define RTH_ASSERT_IMP(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("rgb_to_hsl check failed");

// prop holds on every edge out of reset
`define RTH_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("rgb_to_hsl check failed");

`endif

// File: rtl/rth_pkg.sv
// shared types and constants for the rgb to hsl converter
package rth_pkg;

	localparam int CH_W   = 8;   // color channel
	localparam int HUE_W  = 9;   // hue in degrees
	localparam int PCT_W  = 7;   // percent fields
	localparam int NUM_W  = 17;  // dividend width, holds 360 * 255
	localparam int DEN_W  = 8;   // divisor width
	localparam int QUO_W  = 9;   // quotient bits, one divider stage each
	localparam int SUM_W  = CH_W + 1;

	// lightness = sum * 100 / 510 = (sum * 12851) >> 16, exact for sum up to 510
	localparam int LightRecip = 12851;
	localparam int LightShift = 16;
	localparam int LightMulW  = 23;  // holds 510 * LightRecip
	localparam int SatScale   = 100;
	localparam int ChanMax    = 255;

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	// one classified pixel, ready for the dividers
	typedef struct packed {
		logic [NUM_W-1:0] hue_num;
		logic [DEN_W-1:0] hue_den;
		logic [NUM_W-1:0] sat_num;
		logic [DEN_W-1:0] sat_den;
		logic [PCT_W-1:0] light;
	} work_t;

endpackage

// File: rtl/rth_front.sv
// front end: takes a pixel, finds max, min and sector, forms dividends, divisors and lightness
module rth_front import rth_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  logic [CH_W-1:0] red,
	input  logic [CH_W-1:0] green,
	input  logic [CH_W-1:0] blue,
	output logic            push,
	output work_t           work,
	output logic [1:0]      in_flight
);

	sector_t          sect;
	logic [CH_W-1:0]  hi;
	logic [CH_W-1:0]  lo;
	logic signed [CH_W:0] diff;

	logic             vld_s1;
	sector_t          sect_s1;
	logic [CH_W-1:0]  hi_s1;
	logic [CH_W-1:0]  lo_s1;
	logic signed [CH_W:0] diff_s1;

	logic             vld_s2;
	work_t            work_s2;

	logic [CH_W-1:0]  chroma;
	logic [SUM_W-1:0] sum;
	logic [CH_W-1:0]  dev;
	logic signed [18:0] hue_acc;
	logic signed [18:0] chroma_x;
	logic [LightMulW-1:0] light_prod;
	work_t            work_nx;

	// ties: blue over green over red
	always_comb begin
		if (blue >= red && blue >= green) begin
			sect = SEC_BLUE;
			hi   = blue;
			lo   = (red < green) ? red : green;
			diff = $signed({1'b0, red}) - $signed({1'b0, green});
		end else if (green >= red) begin
			sect = SEC_GREEN;
			hi   = green;
			lo   = (red < blue) ? red : blue;
			diff = $signed({1'b0, blue}) - $signed({1'b0, red});
		end else begin
			sect = SEC_RED;
			hi   = red;
			lo   = (green < blue) ? green : blue;
			diff = $signed({1'b0, green}) - $signed({1'b0, blue});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= take;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		sect_s1 <= sect;
		hi_s1   <= hi;
		lo_s1   <= lo;
		diff_s1 <= diff;
	end

	always_comb begin
		chroma   = hi_s1 - lo_s1;
		sum      = SUM_W'(hi_s1) + SUM_W'(lo_s1);
		dev      = (sum >= SUM_W'(ChanMax)) ? CH_W'(sum - SUM_W'(ChanMax))
			: CH_W'(SUM_W'(ChanMax) - sum);
		chroma_x = $signed({11'b0, chroma});
		hue_acc  = 19'(diff_s1) * 19'sd60;
		unique case (sect_s1)
			SEC_BLUE:  hue_acc = hue_acc + chroma_x * 19'sd240;
			SEC_GREEN: hue_acc = hue_acc + chroma_x * 19'sd120;
			SEC_RED: begin
				if (hue_acc < 0) begin
					hue_acc = hue_acc + chroma_x * 19'sd360;
				end
			end
			default:   hue_acc = '0;
		endcase

		// lightness by reciprocal multiply, exact over the whole sum range
		light_prod    = LightMulW'(sum) * LightMulW'(LightRecip);
		work_nx.light = PCT_W'(light_prod >> LightShift);
		if (chroma == '0) begin
			// gray pixel: hue and saturation come out as 0
			work_nx.hue_num = '0;
			work_nx.hue_den = DEN_W'(1);
			work_nx.sat_num = '0;
			work_nx.sat_den = DEN_W'(1);
		end else begin
			work_nx.hue_num = hue_acc[NUM_W-1:0];
			work_nx.hue_den = chroma;
			work_nx.sat_num = NUM_W'(chroma) * NUM_W'(SatScale);
			work_nx.sat_den = DEN_W'(ChanMax) - dev;
		end
	end

	always_ff @(posedge clk) begin
		work_s2 <= work_nx;
	end

	assign push      = vld_s2;
	assign work      = work_s2;
	assign in_flight = {1'b0, vld_s1} + {1'b0, vld_s2};

endmodule

// File: rtl/rth_queue.sv
// short fifo between front end and dividers
module rth_queue import rth_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  work_t                        wdata,
	output logic                         rvld,
	output work_t                        rdata,
	output logic [$clog2(DEPTH+1)-1:0]   level
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LVL_W = $clog2(DEPTH + 1);

	work_t             mem [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [LVL_W-1:0]  level_q;
	logic              rvld_q;
	work_t             rdata_q;
	logic              pop;

	// the dividers never stall, so drain whenever something is held
	assign pop = (level_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
			rvld_q   <= 1'b0;
		end else begin
			rvld_q <= pop;
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wdata;
		end
		if (pop) begin
			rdata_q <= mem[rd_ptr_q];
		end
	end

	assign rvld  = rvld_q;
	assign rdata = rdata_q;
	assign level = level_q;

endmodule

// File: rtl/rth_div.sv
// pipelined restoring divider, one quotient bit per stage
module rth_div import rth_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             out_vld,
	output logic [QUO_W-1:0] quo
);

	// quotient is known to fit in QUO_W bits
	localparam int W = (NUM_W > DEN_W + QUO_W - 1) ? NUM_W : DEN_W + QUO_W - 1;

	logic             vld_s [QUO_W+1];
	logic [W-1:0]     rem_s [QUO_W+1];
	logic [DEN_W-1:0] den_s [QUO_W+1];
	logic [QUO_W-1:0] quo_s [QUO_W+1];

	assign vld_s[0] = in_vld;
	assign rem_s[0] = W'(num);
	assign den_s[0] = den;
	assign quo_s[0] = '0;

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		logic [W-1:0] shifted;
		logic [W:0]   trial;

		assign shifted = W'(den_s[k]) << (QUO_W - 1 - k);
		assign trial   = {1'b0, rem_s[k]} - {1'b0, shifted};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			den_s[k+1] <= den_s[k];
			if (!trial[W]) begin
				rem_s[k+1] <= trial[W-1:0];
				quo_s[k+1] <= quo_s[k] | (QUO_W'(1) << (QUO_W - 1 - k));
			end else begin
				rem_s[k+1] <= rem_s[k];
				quo_s[k+1] <= quo_s[k];
			end
		end
	end

	assign out_vld = vld_s[QUO_W];
	assign quo     = quo_s[QUO_W];

endmodule

// File: rtl/rth_back.sv
// back end: dividers for hue and saturation, lightness delay line, and the result register
module rth_back import rth_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	input  work_t            work,
	output logic             done,
	output logic [HUE_W-1:0] hue,
	output logic [PCT_W-1:0] saturation,
	output logic [PCT_W-1:0] lightness
);

	logic             hue_vld;
	logic             sat_vld;
	logic [QUO_W-1:0] hue_quo;
	logic [QUO_W-1:0] sat_quo;

	// lightness is already final, delay it to line up with the dividers
	logic [PCT_W-1:0] light_s [QUO_W];

	logic             done_q;
	logic [HUE_W-1:0] hue_q;
	logic [PCT_W-1:0] sat_q;
	logic [PCT_W-1:0] light_q;

	rth_div u_hue_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (in_vld),
		.num     (work.hue_num),
		.den     (work.hue_den),
		.out_vld (hue_vld),
		.quo     (hue_quo)
	);

	rth_div u_sat_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (in_vld),
		.num     (work.sat_num),
		.den     (work.sat_den),
		.out_vld (sat_vld),
		.quo     (sat_quo)
	);

	always_ff @(posedge clk) begin
		light_s[0] <= work.light;
		for (int k = 1; k < QUO_W; k++) begin
			light_s[k] <= light_s[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= hue_vld && sat_vld;
		end
	end

	always_ff @(posedge clk) begin
		hue_q   <= hue_quo[HUE_W-1:0];
		sat_q   <= sat_quo[PCT_W-1:0];
		light_q <= light_s[QUO_W-1];
	end

	assign done       = done_q;
	assign hue        = hue_q;
	assign saturation = sat_q;
	assign lightness  = light_q;

endmodule

// File: rtl/rgb_to_hsl.sv
// rgb to hsl converter top level
//
//   port group                       dir   handshake
//   red, green, blue                 in    start / busy, request taken when start && !busy
//   hue, saturation, lightness       out   done, one cycle per result, no back pressure
//
// one request per clock while busy is low; each request passes in order through
// 2 front stages, the queue memory and its read register, 9 divider stages and 1 output register
// the divider pipelines have 9 stages each, one quotient bit per stage
// busy rises only if the queue plus the front stages could overflow
// reset clears all valid bits and queue pointers; no clearing pass
`include "assert_macros.svh"

module rgb_to_hsl import rth_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [CH_W-1:0]  red,
	input  logic [CH_W-1:0]  green,
	input  logic [CH_W-1:0]  blue,
	output logic             done,
	output logic [HUE_W-1:0] hue,
	output logic [PCT_W-1:0] saturation,
	output logic [PCT_W-1:0] lightness
);

	localparam int LVL_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int Latency = 5 + QUO_W;

	logic             take;
	logic             push;
	work_t            work_front;
	logic [1:0]       in_flight;
	logic             q_vld;
	work_t            work_back;
	logic [LVL_W-1:0] level;

	assign take = start && !busy;
	assign busy = (int'(level) + int'(in_flight)) >= QUEUE_DEPTH;

	rth_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.push      (push),
		.work      (work_front),
		.in_flight (in_flight)
	);

	rth_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (work_front),
		.rvld   (q_vld),
		.rdata  (work_back),
		.level  (level)
	);

	rth_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_vld     (q_vld),
		.work       (work_back),
		.done       (done),
		.hue        (hue),
		.saturation (saturation),
		.lightness  (lightness)
	);

	`RTH_ASSERT_IMP(a_done_latency, done, $past(start && !busy, Latency))
	`RTH_ASSERT_IMP(a_result_range, done, (hue < 9'd360) && (saturation <= 7'd100) && (lightness <= 7'd100))
	`RTH_ASSERT_ALWAYS(a_queue_bound, int'(level) <= QUEUE_DEPTH)

endmodule

// File: bench/rth_checker.sv
// checker for the rgb to hsl converter: predicts each pixel's hsl and compares results
module rth_checker import rth_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  logic [CH_W-1:0]  red,
	input  logic [CH_W-1:0]  green,
	input  logic [CH_W-1:0]  blue,
	input  logic             done,
	input  logic [HUE_W-1:0] hue,
	input  logic [PCT_W-1:0] saturation,
	input  logic [PCT_W-1:0] lightness,
	output int               mismatches,
	output int               outstanding,
	output int               checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [CH_W-1:0]  r;
		logic [CH_W-1:0]  g;
		logic [CH_W-1:0]  b;
		logic [HUE_W-1:0] hue;
		logic [PCT_W-1:0] sat;
		logic [PCT_W-1:0] light;
	} hsl_entry_t;

	hsl_entry_t hsl_pending_q [$];
	int         err_count = 0;
	int         result_count = 0;

	assign mismatches = err_count;
	assign checked    = result_count;

	function automatic hsl_entry_t hsl_of_pixel(input logic [CH_W-1:0] r,
			input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
		hsl_entry_t e;
		int rr, gg, bb, hi, lo, chroma, sum, num, dev, den;
		rr = r;
		gg = g;
		bb = b;
		hi = (rr > gg) ? rr : gg;
		hi = (hi > bb) ? hi : bb;
		lo = (rr < gg) ? rr : gg;
		lo = (lo < bb) ? lo : bb;
		chroma = hi - lo;
		sum = hi + lo;
		e.r = r;
		e.g = g;
		e.b = b;
		e.hue = '0;
		e.sat = '0;
		e.light = PCT_W'((sum * 100) / 510);
		if (chroma != 0) begin
			// blue wins ties over green, green over red
			if (hi == bb)
				num = 60 * (rr - gg) + 240 * chroma;
			else if (hi == gg)
				num = 60 * (bb - rr) + 120 * chroma;
			else begin
				num = 60 * (gg - bb);
				if (num < 0)
					num += 360 * chroma;
			end
			e.hue = HUE_W'(num / chroma);
			dev = sum - 255;
			if (dev < 0)
				dev = -dev;
			den = 255 - dev;
			if (den > 0)
				e.sat = PCT_W'((chroma * 100) / den);
		end
		return e;
	endfunction

	task automatic report_mismatch(input string what, input hsl_entry_t want, input int got,
			input int exp_val);
		if (err_count < 40)
			$display("mismatch %s: rgb %0d,%0d,%0d got %0d want %0d at %0t",
				what, want.r, want.g, want.b, got, exp_val, $realtime);
		err_count++;
	endtask

	always @(posedge clk) begin
		hsl_entry_t want;
		if (arst_n) begin
			if (done) begin
				if (hsl_pending_q.size() == 0)
					report_mismatch("result with no request waiting", '0, 0, 0);
				else begin
					want = hsl_pending_q.pop_front();
					result_count++;
					if (hue !== want.hue)
						report_mismatch("hue", want, hue, want.hue);
					if (saturation !== want.sat)
						report_mismatch("saturation", want, saturation, want.sat);
					if (lightness !== want.light)
						report_mismatch("lightness", want, lightness, want.light);
				end
			end
			if (start && !busy)
				hsl_pending_q.push_back(hsl_of_pixel(red, green, blue));
		end
		outstanding <= hsl_pending_q.size();
	end

endmodule

// File: bench/tb_rgb_to_hsl.sv
// testbench top for the rgb to hsl converter: stimulus, clock, reset and verdict
module tb_rgb_to_hsl import rth_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RandomPixels = 500;
	localparam int CycleLimit   = 200000;
	localparam int DrainCycles  = 24;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [CH_W-1:0]  red;
	logic [CH_W-1:0]  green;
	logic [CH_W-1:0]  blue;
	logic             done;
	logic [HUE_W-1:0] hue;
	logic [PCT_W-1:0] saturation;
	logic [PCT_W-1:0] lightness;
	int               mismatches;
	int               outstanding;
	int               checked;
	int               cycle_count = 0;
	int               sent_count = 0;

	// gray, white, black, primaries, ties, wrap of the red sector, mid-lightness
	logic [3*CH_W-1:0] corner_px [22] = '{
		24'h000000, 24'hffffff, 24'h808080, 24'hff0000, 24'h00ff00, 24'h0000ff,
		24'hffff00, 24'h00ffff, 24'hff00ff, 24'h010000, 24'h000001, 24'hfffefe,
		24'hff0001, 24'hff0100, 24'hfeffff, 24'h7f8080, 24'h807f7f, 24'hc86432,
		24'h3264c8, 24'h64c832, 24'h010100, 24'hfe0000
	};

	rgb_to_hsl u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.done       (done),
		.hue        (hue),
		.saturation (saturation),
		.lightness  (lightness)
	);

	rth_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.done        (done),
		.hue         (hue),
		.saturation  (saturation),
		.lightness   (lightness),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.checked     (checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, outstanding);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic [CH_W-1:0] near(input int base);
		int v;
		v = base + $urandom_range(0, 4) - 2;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return CH_W'(v);
	endfunction

	function automatic logic [CH_W-1:0] edge_chan();
		case ($urandom_range(0, 3))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd254;
			default: return 8'd255;
		endcase
	endfunction

	function automatic logic [3*CH_W-1:0] random_pixel();
		logic [CH_W-1:0] a, b, c;
		int base;
		a = CH_W'($urandom);
		b = CH_W'($urandom);
		c = CH_W'($urandom);
		case ($urandom_range(0, 9))
			6: begin
				// near gray, small chroma
				base = $urandom_range(0, 255);
				a = near(base);
				b = near(base);
				c = near(base);
			end
			7: begin
				// two channels share the maximum or the minimum
				case ($urandom_range(0, 2))
					0: b = a;
					1: c = b;
					default: c = a;
				endcase
			end
			8: begin
				a = edge_chan();
				b = edge_chan();
				c = edge_chan();
			end
			9: begin
				// max + min close to 255, where the saturation divisor peaks
				a = CH_W'($urandom_range(0, 255));
				b = near(255 - a);
				c = CH_W'($urandom_range((a < b) ? a : b, (a > b) ? a : b));
			end
			default: ;
		endcase
		return {a, b, c};
	endfunction

	function automatic int pick_gap(input int idx);
		int k;
		if ((idx % 100) < 25)
			return 0;
		k = $urandom_range(0, 99);
		if (k < 60)
			return 0;
		if (k < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// present one request and hold it until the block takes it
	task automatic send_pixel(input logic [3*CH_W-1:0] px, input int gap);
		start <= 1'b1;
		{red, green, blue} <= px;
		do @(posedge clk); while (busy);
		sent_count++;
		if (gap > 0) begin
			start <= 1'b0;
			{red, green, blue} <= (3*CH_W)'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		start  <= 1'b0;
		red    <= '0;
		green  <= '0;
		blue   <= '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corner_px[i])
			send_pixel(corner_px[i], (i % 5 == 4) ? $urandom_range(1, 6) : 0);
		for (int i = 0; i < RandomPixels; i++)
			send_pixel(random_pixel(), pick_gap(i));
		start <= 1'b0;

		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("sent %0d pixels (%0d corner cases, rest random), checked %0d results",
			sent_count, $size(corner_px), checked);
		$display("%0d mismatches, %0d results still outstanding", mismatches, outstanding);
		if (mismatches == 0 && outstanding == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
